>>> rtl/htok_pkg.sv
// Shared types for the streaming HTML tokenizer: item structs, event codes
// and the one-hot tokenizer state type. No dependencies.
`timescale 1ns / 1ps
package htok_pkg;

    localparam int MaxEvents = 10;

    typedef enum logic [3:0] {
        EV_CHAR      = 4'd0,
        EV_START_TAG = 4'd1,
        EV_END_TAG   = 4'd2,
        EV_TAG_CHAR  = 4'd3,
        EV_TAG_CLOSE = 4'd4,
        EV_CMT_OPEN  = 4'd5,
        EV_CMT_CHAR  = 4'd6,
        EV_CMT_CLOSE = 4'd7,
        EV_DT_OPEN   = 4'd8,
        EV_DT_CHAR   = 4'd9,
        EV_DT_CLOSE  = 4'd10,
        EV_EOF       = 4'd11
    } ev_kind_t;

    typedef enum logic [29:0] {
        M_DATA              = 30'h0000_0001,
        M_TAG_OPEN          = 30'h0000_0002,
        M_END_TAG_OPEN      = 30'h0000_0004,
        M_TAG_NAME          = 30'h0000_0008,
        M_BEFORE_ATTR       = 30'h0000_0010,
        M_ATTR_NAME         = 30'h0000_0020,
        M_AFTER_ATTR        = 30'h0000_0040,
        M_BEFORE_VAL        = 30'h0000_0080,
        M_VAL_DQ            = 30'h0000_0100,
        M_VAL_SQ            = 30'h0000_0200,
        M_VAL_UQ            = 30'h0000_0400,
        M_AFTER_VAL         = 30'h0000_0800,
        M_SELF_CLOSE        = 30'h0000_1000,
        M_MARKUP            = 30'h0000_2000,
        M_CMT_START         = 30'h0000_4000,
        M_CMT_START_DASH    = 30'h0000_8000,
        M_CMT               = 30'h0001_0000,
        M_CMT_LT            = 30'h0002_0000,
        M_CMT_LT_BANG       = 30'h0004_0000,
        M_CMT_LT_BANG_DASH  = 30'h0008_0000,
        M_CMT_LT_BANG_DD    = 30'h0010_0000,
        M_CMT_END_DASH      = 30'h0020_0000,
        M_CMT_END           = 30'h0040_0000,
        M_CMT_END_BANG      = 30'h0080_0000,
        M_BOGUS_CMT         = 30'h0100_0000,
        M_DOCTYPE           = 30'h0200_0000,
        M_BEFORE_DT_NAME    = 30'h0400_0000,
        M_DT_NAME           = 30'h0800_0000,
        M_AFTER_DT_NAME     = 30'h1000_0000,
        M_BOGUS_DT          = 30'h2000_0000
    } mode_t;

    typedef struct packed {
        logic [7:0] input_byte;
        logic       end_of_input;
    } byte_item_t;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [15:0] char_code;
        logic        slash_end;
        logic        quirks;
        logic        last;
    } event_item_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [15:0] code;
        logic        sc;
        logic        fq;
    } event_t;

    // All events caused by one item, oldest in entry zero.
    typedef struct packed {
        logic [3:0]                 count;
        event_t [MaxEvents-1:0]     ev;
    } batch_t;

endpackage

>>> rtl/html_tokenizer_stream.sv
// Streaming HTML tokenizer: one byte or end marker per item in, token events out.
// An accepted item is registered; its events load into the event bank when it is free.
// Throughput: one item per cycle while each item yields at most one event and
// the receiver does not stall; an item with more holds the input as the bank drains.
// Reset puts the tokenizer in the data state, clears halt and empties the bank.
// Depends on htok_pkg, htok_core and htok_evq.
`timescale 1ns / 1ps
module html_tokenizer_stream (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  htok_pkg::byte_item_t  byte_item,
    output logic                  event_valid,
    input  logic                  event_stall,
    output htok_pkg::event_item_t event_item
);
    import htok_pkg::*;

    logic   buf_free;
    logic   load;
    batch_t batch;

    htok_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (byte_valid),
        .stall    (byte_stall),
        .item     (byte_item),
        .buf_free (buf_free),
        .load     (load),
        .batch    (batch)
    );

    htok_evq u_evq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .batch    (batch),
        .buf_free (buf_free),
        .valid    (event_valid),
        .stall    (event_stall),
        .item     (event_item)
    );

endmodule

>>> rtl/htok_core.sv
// Input register, tokenizer state and the per-item transition logic.
// Depends on htok_pkg.
`timescale 1ns / 1ps
module htok_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  htok_pkg::byte_item_t item,
    input  logic                buf_free,
    output logic                load,
    output htok_pkg::batch_t    batch
);
    import htok_pkg::*;

    localparam logic [7:0] KwDoctype [7] = '{8'h64, 8'h6F, 8'h63, 8'h74, 8'h79, 8'h70, 8'h65};
    localparam logic [7:0] KwCdata [7] = '{8'h5B, 8'h43, 8'h44, 8'h41, 8'h54, 8'h41, 8'h5B};
    localparam logic [15:0] Replacement = 16'hFFFD;

    logic       item_valid_reg;
    byte_item_t item_reg;
    mode_t      mode_reg, mode_next;
    logic [2:0] n_reg, n_next;
    logic [2:0] cand_reg, cand_next;
    logic [7:0] kb_reg [6];
    logic [7:0] kb_next [6];
    logic       halt_reg, halt_next;

    function automatic event_t mk(ev_kind_t k, logic [15:0] code, logic sc, logic fq);
        event_t e;
        e.kind = k;
        e.code = code;
        e.sc = sc;
        e.fq = fq;
        return e;
    endfunction

    assign load  = item_valid_reg && buf_free;
    assign stall = item_valid_reg && !buf_free;

    always_comb
    begin
        mode_t       m;
        logic        go;
        logic        again;
        logic [3:0]  cnt;
        logic [7:0]  c;
        logic        eof;
        logic        ws;
        logic        up;
        logic        alpha;
        logic [15:0] cv;
        logic [15:0] lowv;
        logic [7:0]  low;
        logic [2:0]  cd;
        m = mode_reg;
        n_next = n_reg;
        cand_next = cand_reg;
        halt_next = halt_reg;
        for (int k = 0; k < 6; k++)
        begin
            kb_next[k] = kb_reg[k];
        end
        batch = '0;
        cnt = 4'd0;
        again = 1'b0;
        cd = 3'd0;
        c = item_reg.input_byte;
        eof = item_reg.end_of_input;
        ws = (c == 8'd9) || (c == 8'd10) || (c == 8'd12) || (c == 8'd32);
        up = (c >= 8'h41) && (c <= 8'h5A);
        alpha = up || ((c >= 8'h61) && (c <= 8'h7A));
        cv = (c == 8'd0) ? Replacement : {8'h00, c};
        low = up ? (c + 8'h20) : c;
        lowv = up ? {8'h00, low} : cv;
        go = 1'b1;
        if (halt_reg)
        begin
            batch.ev[cnt] = mk(EV_EOF, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
            go = 1'b0;
        end
        for (int it = 0; it < 4; it++)
        begin
            if (go)
            begin
                again = 1'b0;
                case (m)
                    M_DATA:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_EOF, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                        end
                        else if (c == 8'h3C) m = M_TAG_OPEN;
                        else
                        begin
                            batch.ev[cnt] = mk(EV_CHAR, cv, 1'b0, 1'b0); cnt = cnt + 4'd1;
                        end
                    end
                    M_TAG_OPEN:
                    begin
                        if (!eof && c == 8'h21)
                        begin
                            m = M_MARKUP;
                            n_next = 3'd0;
                            cand_next = 3'd7;
                        end
                        else if (!eof && c == 8'h2F) m = M_END_TAG_OPEN;
                        else if (!eof && alpha)
                        begin
                            batch.ev[cnt] = mk(EV_START_TAG, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_TAG_NAME; again = 1'b1;
                        end
                        else if (!eof && c == 8'h3F)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_OPEN, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_BOGUS_CMT; again = 1'b1;
                        end
                        else
                        begin
                            batch.ev[cnt] = mk(EV_CHAR, 16'h003C, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                    end
                    M_END_TAG_OPEN:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_CHAR, 16'h003C, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            batch.ev[cnt] = mk(EV_CHAR, 16'h002F, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (alpha)
                        begin
                            batch.ev[cnt] = mk(EV_END_TAG, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_TAG_NAME; again = 1'b1;
                        end
                        else if (c == 8'h3E) m = M_DATA;
                        else
                        begin
                            batch.ev[cnt] = mk(EV_CMT_OPEN, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_BOGUS_CMT; again = 1'b1;
                        end
                    end
                    M_TAG_NAME:
                    begin
                        if (eof)
                        begin
                            m = M_DATA; again = 1'b1;
                        end
                        else if (ws) m = M_BEFORE_ATTR;
                        else if (c == 8'h2F) m = M_SELF_CLOSE;
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_TAG_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            batch.ev[cnt] = mk(EV_TAG_CHAR, lowv, 1'b0, 1'b0); cnt = cnt + 4'd1;
                        end
                    end
                    M_BEFORE_ATTR:
                    begin
                        if (eof)
                        begin
                            m = M_DATA; again = 1'b1;
                        end
                        else if (ws) m = M_BEFORE_ATTR;
                        else if (c == 8'h2F || c == 8'h3E)
                        begin
                            m = M_AFTER_ATTR; again = 1'b1;
                        end
                        else if (c == 8'h3D) m = M_ATTR_NAME;
                        else
                        begin
                            m = M_ATTR_NAME; again = 1'b1;
                        end
                    end
                    M_ATTR_NAME:
                    begin
                        if (eof)
                        begin
                            m = M_DATA; again = 1'b1;
                        end
                        else if (ws || c == 8'h2F || c == 8'h3E)
                        begin
                            m = M_AFTER_ATTR; again = 1'b1;
                        end
                        else if (c == 8'h3D) m = M_BEFORE_VAL;
                    end
                    M_AFTER_ATTR:
                    begin
                        if (eof)
                        begin
                            m = M_DATA; again = 1'b1;
                        end
                        else if (ws) m = M_AFTER_ATTR;
                        else if (c == 8'h2F) m = M_SELF_CLOSE;
                        else if (c == 8'h3D) m = M_BEFORE_VAL;
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_TAG_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            m = M_ATTR_NAME; again = 1'b1;
                        end
                    end
                    M_BEFORE_VAL:
                    begin
                        if (eof)
                        begin
                            m = M_DATA; again = 1'b1;
                        end
                        else if (ws) m = M_BEFORE_VAL;
                        else if (c == 8'h22) m = M_VAL_DQ;
                        else if (c == 8'h27) m = M_VAL_SQ;
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_TAG_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            m = M_VAL_UQ; again = 1'b1;
                        end
                    end
                    M_VAL_DQ:
                    begin
                        if (eof)
                        begin
                            m = M_DATA; again = 1'b1;
                        end
                        else if (c == 8'h22) m = M_AFTER_VAL;
                    end
                    M_VAL_SQ:
                    begin
                        if (eof)
                        begin
                            m = M_DATA; again = 1'b1;
                        end
                        else if (c == 8'h27) m = M_AFTER_VAL;
                    end
                    M_VAL_UQ:
                    begin
                        if (eof)
                        begin
                            m = M_DATA; again = 1'b1;
                        end
                        else if (ws) m = M_BEFORE_ATTR;
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_TAG_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                    end
                    M_AFTER_VAL:
                    begin
                        if (eof)
                        begin
                            m = M_DATA; again = 1'b1;
                        end
                        else if (ws) m = M_BEFORE_ATTR;
                        else if (c == 8'h2F) m = M_SELF_CLOSE;
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_TAG_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            m = M_BEFORE_ATTR; again = 1'b1;
                        end
                    end
                    M_SELF_CLOSE:
                    begin
                        if (eof)
                        begin
                            m = M_DATA; again = 1'b1;
                        end
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_TAG_CLOSE, 16'd0, 1'b1, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            m = M_BEFORE_ATTR; again = 1'b1;
                        end
                    end
                    M_MARKUP:
                    begin
                        cd = cand_next;
                        if (eof || n_next == 3'd7) cd = 3'd0;
                        else
                        begin
                            if (!(n_next < 3'd2 && c == 8'h2D)) cd[0] = 1'b0;
                            if (low != KwDoctype[n_next]) cd[1] = 1'b0;
                            if (c != KwCdata[n_next]) cd[2] = 1'b0;
                        end
                        if (cd[0] && n_next == 3'd1)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_OPEN, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_CMT_START;
                        end
                        else if (cd[1] && n_next == 3'd6) m = M_DOCTYPE;
                        else if (cd[2] && n_next == 3'd6)
                        begin
                            // Start of a CDATA section ends the stream for good.
                            batch.ev[cnt] = mk(EV_EOF, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            halt_next = 1'b1;
                            m = M_DATA;
                        end
                        else if (cd != 3'd0 && n_next < 3'd6)
                        begin
                            kb_next[n_next] = c;
                            n_next = n_next + 3'd1;
                            cand_next = cd;
                        end
                        else
                        begin
                            // Mismatch: replay the buffered bytes as a bogus comment.
                            batch.ev[cnt] = mk(EV_CMT_OPEN, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            for (int i = 0; i < 6; i++)
                            begin
                                if (3'(i) < n_next)
                                begin
                                    batch.ev[cnt] = mk(EV_CMT_CHAR, {8'h00, kb_reg[i]}, 1'b0, 1'b0);
                                    cnt = cnt + 4'd1;
                                end
                            end
                            n_next = 3'd0;
                            cand_next = 3'd0;
                            m = M_BOGUS_CMT; again = 1'b1;
                        end
                    end
                    M_CMT_START:
                    begin
                        if (!eof && c == 8'h2D) m = M_CMT_START_DASH;
                        else if (!eof && c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            m = M_CMT; again = 1'b1;
                        end
                    end
                    M_CMT_START_DASH:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (c == 8'h2D) m = M_CMT_END;
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CHAR, 16'h002D, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_CMT; again = 1'b1;
                        end
                    end
                    M_CMT:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (c == 8'h3C)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CHAR, 16'h003C, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_CMT_LT;
                        end
                        else if (c == 8'h2D) m = M_CMT_END_DASH;
                        else
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CHAR, cv, 1'b0, 1'b0); cnt = cnt + 4'd1;
                        end
                    end
                    M_CMT_LT:
                    begin
                        if (!eof && c == 8'h21)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CHAR, 16'h0021, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_CMT_LT_BANG;
                        end
                        else if (!eof && c == 8'h3C)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CHAR, 16'h003C, 1'b0, 1'b0); cnt = cnt + 4'd1;
                        end
                        else
                        begin
                            m = M_CMT; again = 1'b1;
                        end
                    end
                    M_CMT_LT_BANG:
                    begin
                        if (!eof && c == 8'h2D) m = M_CMT_LT_BANG_DASH;
                        else
                        begin
                            m = M_CMT; again = 1'b1;
                        end
                    end
                    M_CMT_LT_BANG_DASH:
                    begin
                        if (!eof && c == 8'h2D) m = M_CMT_LT_BANG_DD;
                        else
                        begin
                            m = M_CMT_END_DASH; again = 1'b1;
                        end
                    end
                    M_CMT_LT_BANG_DD:
                    begin
                        m = M_CMT_END; again = 1'b1;
                    end
                    M_CMT_END_DASH:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (c == 8'h2D) m = M_CMT_END;
                        else
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CHAR, 16'h002D, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_CMT; again = 1'b1;
                        end
                    end
                    M_CMT_END:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else if (c == 8'h21) m = M_CMT_END_BANG;
                        else if (c == 8'h2D)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CHAR, 16'h002D, 1'b0, 1'b0); cnt = cnt + 4'd1;
                        end
                        else
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CHAR, 16'h002D, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            batch.ev[cnt] = mk(EV_CMT_CHAR, 16'h002D, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_CMT; again = 1'b1;
                        end
                    end
                    M_CMT_END_BANG:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CHAR, 16'h002D, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            batch.ev[cnt] = mk(EV_CMT_CHAR, 16'h002D, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            batch.ev[cnt] = mk(EV_CMT_CHAR, 16'h0021, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            if (c == 8'h2D) m = M_CMT_END_DASH;
                            else
                            begin
                                m = M_CMT; again = 1'b1;
                            end
                        end
                    end
                    M_BOGUS_CMT:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            batch.ev[cnt] = mk(EV_CMT_CHAR, cv, 1'b0, 1'b0); cnt = cnt + 4'd1;
                        end
                    end
                    M_DOCTYPE:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_DT_OPEN, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            batch.ev[cnt] = mk(EV_DT_CLOSE, 16'd0, 1'b0, 1'b1); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (ws) m = M_BEFORE_DT_NAME;
                        else
                        begin
                            m = M_BEFORE_DT_NAME; again = 1'b1;
                        end
                    end
                    M_BEFORE_DT_NAME:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_DT_OPEN, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            batch.ev[cnt] = mk(EV_DT_CLOSE, 16'd0, 1'b0, 1'b1); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (ws) m = M_BEFORE_DT_NAME;
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_DT_OPEN, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            batch.ev[cnt] = mk(EV_DT_CLOSE, 16'd0, 1'b0, 1'b1); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            batch.ev[cnt] = mk(EV_DT_OPEN, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            batch.ev[cnt] = mk(EV_DT_CHAR, lowv, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DT_NAME;
                        end
                    end
                    M_DT_NAME:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_DT_CLOSE, 16'd0, 1'b0, 1'b1); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (ws) m = M_AFTER_DT_NAME;
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_DT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            batch.ev[cnt] = mk(EV_DT_CHAR, lowv, 1'b0, 1'b0); cnt = cnt + 4'd1;
                        end
                    end
                    M_AFTER_DT_NAME:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_DT_CLOSE, 16'd0, 1'b0, 1'b1); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (ws) m = M_AFTER_DT_NAME;
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_DT_CLOSE, 16'd0, 1'b0, 1'b0); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                        else
                        begin
                            m = M_BOGUS_DT; again = 1'b1;
                        end
                    end
                    M_BOGUS_DT:
                    begin
                        if (eof)
                        begin
                            batch.ev[cnt] = mk(EV_DT_CLOSE, 16'd0, 1'b0, 1'b1); cnt = cnt + 4'd1;
                            m = M_DATA; again = 1'b1;
                        end
                        else if (c == 8'h3E)
                        begin
                            batch.ev[cnt] = mk(EV_DT_CLOSE, 16'd0, 1'b0, 1'b1); cnt = cnt + 4'd1;
                            m = M_DATA;
                        end
                    end
                    default:
                    begin
                        m = M_DATA; again = 1'b1;
                    end
                endcase
                go = again;
            end
        end
        batch.count = cnt;
        mode_next = m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            mode_reg <= M_DATA;
            n_reg <= 3'd0;
            cand_reg <= 3'd0;
            halt_reg <= 1'b0;
        end
        else
        begin
            if (valid && !stall)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                item_valid_reg <= 1'b0;
            end
            if (load)
            begin
                mode_reg <= mode_next;
                n_reg <= n_next;
                cand_reg <= cand_next;
                halt_reg <= halt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid && !stall)
        begin
            item_reg <= item;
        end
        if (load)
        begin
            for (int k = 0; k < 6; k++)
            begin
                kb_reg[k] <= kb_next[k];
            end
        end
    end

endmodule

>>> rtl/htok_evq.sv
// Result register bank holding the events of one item and handing them out
// one per cycle while the receiver does not stall. Depends on htok_pkg.
`timescale 1ns / 1ps
module htok_evq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  htok_pkg::batch_t      batch,
    output logic                  buf_free,
    output logic                  valid,
    input  logic                  stall,
    output htok_pkg::event_item_t item
);
    import htok_pkg::*;

    logic [3:0]             cnt_reg;
    event_t [MaxEvents-1:0] q_reg;
    logic                   pop;

    assign valid    = (cnt_reg != 4'd0);
    assign pop      = valid && !stall;
    assign buf_free = (cnt_reg == 4'd0) || ((cnt_reg == 4'd1) && !stall);

    assign item.event_kind = q_reg[0].kind;
    assign item.char_code  = q_reg[0].code;
    assign item.slash_end  = q_reg[0].sc;
    assign item.quirks     = q_reg[0].fq;
    assign item.last       = (cnt_reg == 4'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 4'd0;
        end
        else if (load)
        begin
            cnt_reg <= batch.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    // The head event always sits in entry zero; a pop shifts the rest down.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= batch.ev;
        end
        else if (pop)
        begin
            for (int i = 0; i < MaxEvents - 1; i++)
            begin
                q_reg[i] <= q_reg[i+1];
            end
        end
    end

endmodule

>>> tb/htok_checker.sv
// Watches both channels of the HTML tokenizer, predicts the token events of
// each accepted byte item and compares them with what comes out. Uses htok_pkg.
`timescale 1ns / 1ps
module htok_checker (
    input  logic                  clk,
    input  logic                  byte_valid,
    input  logic                  byte_stall,
    input  htok_pkg::byte_item_t  byte_item,
    input  logic                  event_valid,
    input  logic                  event_stall,
    input  htok_pkg::event_item_t event_item,
    output int                    errors,
    output int                    pending,
    output int                    events_seen
);
    import htok_pkg::*;

    event_item_t expected_events[$];
    mode_t       tok_mode;
    logic [2:0]  kw_count;
    logic [2:0]  kw_cand;
    logic [7:0]  kw_bytes[6];
    logic        is_halted;
    event_item_t item_events[$];

    localparam logic [7:0] DoctypeKw[7] = '{8'h64, 8'h6f, 8'h63, 8'h74, 8'h79, 8'h70, 8'h65};
    localparam logic [7:0] CdataKw[7] = '{8'h5b, 8'h43, 8'h44, 8'h41, 8'h54, 8'h41, 8'h5b};

    initial
    begin
        errors = 0;
        pending = 0;
        events_seen = 0;
        tok_mode = M_DATA;
        kw_count = 0;
        kw_cand = 0;
        is_halted = 0;
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic add_event(input ev_kind_t k, input logic [15:0] code,
                             input logic sc = 0, input logic fq = 0);
        event_item_t e;
        if (item_events.size() >= MaxEvents)
            return;
        e.event_kind = k;
        e.char_code = code;
        e.slash_end = sc;
        e.quirks = fq;
        e.last = 0;
        item_events.push_back(e);
    endtask

    function automatic logic ws(input logic [7:0] c);
        return c == 8'd9 || c == 8'd10 || c == 8'd12 || c == 8'd32;
    endfunction

    function automatic logic upper(input logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic logic alpha(input logic [7:0] c);
        return upper(c) || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [15:0] nul_fix(input logic [7:0] c);
        return c == 0 ? 16'hFFFD : {8'h00, c};
    endfunction

    function automatic logic [15:0] fold(input logic [7:0] c);
        return upper(c) ? {8'h00, c | 8'h20} : nul_fix(c);
    endfunction

    // Runs the tokenizer over one byte, reconsuming until a state consumes it.
    task automatic tokenize(input logic [7:0] c, input logic eoi);
        logic again;
        logic [2:0] cand;
        logic [7:0] low;
        int n;
        for (int g = 0; g < 32; g++)
        begin
            again = 0;
            case (tok_mode)
                M_DATA:
                    if (eoi)
                    begin
                        add_event(EV_EOF, 0);
                        return;
                    end
                    else if (c == "<") tok_mode = M_TAG_OPEN;
                    else add_event(EV_CHAR, nul_fix(c));
                M_TAG_OPEN:
                    if (!eoi && c == "!")
                    begin
                        tok_mode = M_MARKUP;
                        kw_count = 0;
                        kw_cand = 3'd7;
                    end
                    else if (!eoi && c == "/") tok_mode = M_END_TAG_OPEN;
                    else if (!eoi && alpha(c))
                    begin
                        add_event(EV_START_TAG, 0);
                        tok_mode = M_TAG_NAME;
                        again = 1;
                    end
                    else if (!eoi && c == "?")
                    begin
                        add_event(EV_CMT_OPEN, 0);
                        tok_mode = M_BOGUS_CMT;
                        again = 1;
                    end
                    else
                    begin
                        add_event(EV_CHAR, 16'h003C);
                        tok_mode = M_DATA;
                        again = 1;
                    end
                M_END_TAG_OPEN:
                    if (eoi)
                    begin
                        add_event(EV_CHAR, 16'h003C);
                        add_event(EV_CHAR, 16'h002F);
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (alpha(c))
                    begin
                        add_event(EV_END_TAG, 0);
                        tok_mode = M_TAG_NAME;
                        again = 1;
                    end
                    else if (c == ">") tok_mode = M_DATA;
                    else
                    begin
                        add_event(EV_CMT_OPEN, 0);
                        tok_mode = M_BOGUS_CMT;
                        again = 1;
                    end
                M_TAG_NAME:
                    if (eoi)
                    begin
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (ws(c)) tok_mode = M_BEFORE_ATTR;
                    else if (c == "/") tok_mode = M_SELF_CLOSE;
                    else if (c == ">")
                    begin
                        add_event(EV_TAG_CLOSE, 0);
                        tok_mode = M_DATA;
                    end
                    else add_event(EV_TAG_CHAR, fold(c));
                M_BEFORE_ATTR:
                    if (eoi)
                    begin
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (ws(c)) ;
                    else if (c == "/" || c == ">")
                    begin
                        tok_mode = M_AFTER_ATTR;
                        again = 1;
                    end
                    else if (c == "=") tok_mode = M_ATTR_NAME;
                    else
                    begin
                        tok_mode = M_ATTR_NAME;
                        again = 1;
                    end
                M_ATTR_NAME:
                    if (eoi)
                    begin
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (ws(c) || c == "/" || c == ">")
                    begin
                        tok_mode = M_AFTER_ATTR;
                        again = 1;
                    end
                    else if (c == "=") tok_mode = M_BEFORE_VAL;
                M_AFTER_ATTR:
                    if (eoi)
                    begin
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (ws(c)) ;
                    else if (c == "/") tok_mode = M_SELF_CLOSE;
                    else if (c == "=") tok_mode = M_BEFORE_VAL;
                    else if (c == ">")
                    begin
                        add_event(EV_TAG_CLOSE, 0);
                        tok_mode = M_DATA;
                    end
                    else
                    begin
                        tok_mode = M_ATTR_NAME;
                        again = 1;
                    end
                M_BEFORE_VAL:
                    if (eoi)
                    begin
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (ws(c)) ;
                    else if (c == "\"") tok_mode = M_VAL_DQ;
                    else if (c == "'") tok_mode = M_VAL_SQ;
                    else if (c == ">")
                    begin
                        add_event(EV_TAG_CLOSE, 0);
                        tok_mode = M_DATA;
                    end
                    else
                    begin
                        tok_mode = M_VAL_UQ;
                        again = 1;
                    end
                M_VAL_DQ, M_VAL_SQ:
                    if (eoi)
                    begin
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (c == (tok_mode == M_VAL_DQ ? 8'h22 : 8'h27))
                        tok_mode = M_AFTER_VAL;
                M_VAL_UQ:
                    if (eoi)
                    begin
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (ws(c)) tok_mode = M_BEFORE_ATTR;
                    else if (c == ">")
                    begin
                        add_event(EV_TAG_CLOSE, 0);
                        tok_mode = M_DATA;
                    end
                M_AFTER_VAL:
                    if (eoi)
                    begin
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (ws(c)) tok_mode = M_BEFORE_ATTR;
                    else if (c == "/") tok_mode = M_SELF_CLOSE;
                    else if (c == ">")
                    begin
                        add_event(EV_TAG_CLOSE, 0);
                        tok_mode = M_DATA;
                    end
                    else
                    begin
                        tok_mode = M_BEFORE_ATTR;
                        again = 1;
                    end
                M_SELF_CLOSE:
                    if (eoi)
                    begin
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (c == ">")
                    begin
                        add_event(EV_TAG_CLOSE, 0, 1);
                        tok_mode = M_DATA;
                    end
                    else
                    begin
                        tok_mode = M_BEFORE_ATTR;
                        again = 1;
                    end
                M_MARKUP:
                begin
                    cand = kw_cand;
                    n = kw_count;
                    if (eoi || n >= 7) cand = 0;
                    else
                    begin
                        low = upper(c) ? (c | 8'h20) : c;
                        if (!(n < 2 && c == "-")) cand[0] = 0;
                        if (low != DoctypeKw[n]) cand[1] = 0;
                        if (c != CdataKw[n]) cand[2] = 0;
                    end
                    if (cand[0] && n == 1)
                    begin
                        add_event(EV_CMT_OPEN, 0);
                        tok_mode = M_CMT_START;
                    end
                    else if (cand[1] && n == 6) tok_mode = M_DOCTYPE;
                    else if (cand[2] && n == 6)
                    begin
                        add_event(EV_EOF, 0);
                        is_halted = 1;
                        tok_mode = M_DATA;
                        return;
                    end
                    else if (cand != 0 && n < 6)
                    begin
                        kw_bytes[n] = c;
                        kw_count = 3'(n + 1);
                        kw_cand = cand;
                    end
                    else
                    begin
                        // Keyword lookahead failed: replay it as bogus comment text.
                        add_event(EV_CMT_OPEN, 0);
                        for (int i = 0; i < n && i < 6; i++)
                            add_event(EV_CMT_CHAR, {8'h00, kw_bytes[i]});
                        kw_count = 0;
                        kw_cand = 0;
                        tok_mode = M_BOGUS_CMT;
                        again = 1;
                    end
                end
                M_CMT_START:
                    if (!eoi && c == "-") tok_mode = M_CMT_START_DASH;
                    else if (!eoi && c == ">")
                    begin
                        add_event(EV_CMT_CLOSE, 0);
                        tok_mode = M_DATA;
                    end
                    else
                    begin
                        tok_mode = M_CMT;
                        again = 1;
                    end
                M_CMT_START_DASH:
                    if (eoi)
                    begin
                        add_event(EV_CMT_CLOSE, 0);
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (c == "-") tok_mode = M_CMT_END;
                    else if (c == ">")
                    begin
                        add_event(EV_CMT_CLOSE, 0);
                        tok_mode = M_DATA;
                    end
                    else
                    begin
                        add_event(EV_CMT_CHAR, 16'h002D);
                        tok_mode = M_CMT;
                        again = 1;
                    end
                M_CMT:
                    if (eoi)
                    begin
                        add_event(EV_CMT_CLOSE, 0);
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (c == "<")
                    begin
                        add_event(EV_CMT_CHAR, 16'h003C);
                        tok_mode = M_CMT_LT;
                    end
                    else if (c == "-") tok_mode = M_CMT_END_DASH;
                    else add_event(EV_CMT_CHAR, nul_fix(c));
                M_CMT_LT:
                    if (!eoi && c == "!")
                    begin
                        add_event(EV_CMT_CHAR, 16'h0021);
                        tok_mode = M_CMT_LT_BANG;
                    end
                    else if (!eoi && c == "<") add_event(EV_CMT_CHAR, 16'h003C);
                    else
                    begin
                        tok_mode = M_CMT;
                        again = 1;
                    end
                M_CMT_LT_BANG:
                    if (!eoi && c == "-") tok_mode = M_CMT_LT_BANG_DASH;
                    else
                    begin
                        tok_mode = M_CMT;
                        again = 1;
                    end
                M_CMT_LT_BANG_DASH:
                    if (!eoi && c == "-") tok_mode = M_CMT_LT_BANG_DD;
                    else
                    begin
                        tok_mode = M_CMT_END_DASH;
                        again = 1;
                    end
                M_CMT_LT_BANG_DD:
                begin
                    tok_mode = M_CMT_END;
                    again = 1;
                end
                M_CMT_END_DASH:
                    if (eoi)
                    begin
                        add_event(EV_CMT_CLOSE, 0);
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (c == "-") tok_mode = M_CMT_END;
                    else
                    begin
                        add_event(EV_CMT_CHAR, 16'h002D);
                        tok_mode = M_CMT;
                        again = 1;
                    end
                M_CMT_END:
                    if (eoi)
                    begin
                        add_event(EV_CMT_CLOSE, 0);
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (c == ">")
                    begin
                        add_event(EV_CMT_CLOSE, 0);
                        tok_mode = M_DATA;
                    end
                    else if (c == "!") tok_mode = M_CMT_END_BANG;
                    else if (c == "-") add_event(EV_CMT_CHAR, 16'h002D);
                    else
                    begin
                        add_event(EV_CMT_CHAR, 16'h002D);
                        add_event(EV_CMT_CHAR, 16'h002D);
                        tok_mode = M_CMT;
                        again = 1;
                    end
                M_CMT_END_BANG:
                    if (eoi)
                    begin
                        add_event(EV_CMT_CLOSE, 0);
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (c == ">")
                    begin
                        add_event(EV_CMT_CLOSE, 0);
                        tok_mode = M_DATA;
                    end
                    else
                    begin
                        add_event(EV_CMT_CHAR, 16'h002D);
                        add_event(EV_CMT_CHAR, 16'h002D);
                        add_event(EV_CMT_CHAR, 16'h0021);
                        if (c == "-") tok_mode = M_CMT_END_DASH;
                        else
                        begin
                            tok_mode = M_CMT;
                            again = 1;
                        end
                    end
                M_BOGUS_CMT:
                    if (eoi)
                    begin
                        add_event(EV_CMT_CLOSE, 0);
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (c == ">")
                    begin
                        add_event(EV_CMT_CLOSE, 0);
                        tok_mode = M_DATA;
                    end
                    else add_event(EV_CMT_CHAR, nul_fix(c));
                M_DOCTYPE, M_BEFORE_DT_NAME:
                    if (eoi)
                    begin
                        add_event(EV_DT_OPEN, 0);
                        add_event(EV_DT_CLOSE, 0, 0, 1);
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (tok_mode == M_DOCTYPE)
                    begin
                        tok_mode = M_BEFORE_DT_NAME;
                        again = !ws(c);
                    end
                    else if (ws(c)) ;
                    else if (c == ">")
                    begin
                        add_event(EV_DT_OPEN, 0);
                        add_event(EV_DT_CLOSE, 0, 0, 1);
                        tok_mode = M_DATA;
                    end
                    else
                    begin
                        add_event(EV_DT_OPEN, 0);
                        add_event(EV_DT_CHAR, fold(c));
                        tok_mode = M_DT_NAME;
                    end
                M_DT_NAME, M_AFTER_DT_NAME:
                    if (eoi)
                    begin
                        add_event(EV_DT_CLOSE, 0, 0, 1);
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (ws(c)) tok_mode = M_AFTER_DT_NAME;
                    else if (c == ">")
                    begin
                        add_event(EV_DT_CLOSE, 0);
                        tok_mode = M_DATA;
                    end
                    else if (tok_mode == M_DT_NAME) add_event(EV_DT_CHAR, fold(c));
                    else
                    begin
                        tok_mode = M_BOGUS_DT;
                        again = 1;
                    end
                M_BOGUS_DT:
                    if (eoi)
                    begin
                        add_event(EV_DT_CLOSE, 0, 0, 1);
                        tok_mode = M_DATA;
                        again = 1;
                    end
                    else if (c == ">")
                    begin
                        add_event(EV_DT_CLOSE, 0, 0, 1);
                        tok_mode = M_DATA;
                    end
                default:
                begin
                    tok_mode = M_DATA;
                    again = 1;
                end
            endcase
            if (!again)
                return;
        end
    endtask

    always @(posedge clk)
    begin
        event_item_t exp_ev;
        if (byte_valid && !byte_stall)
        begin
            item_events.delete();
            if (is_halted) add_event(EV_EOF, 0);
            else tokenize(byte_item.input_byte, byte_item.end_of_input);
            if (item_events.size() > 0)
                item_events[item_events.size()-1].last = 1;
            foreach (item_events[i])
                expected_events.push_back(item_events[i]);
        end
        if (event_valid && !event_stall)
        begin
            events_seen++;
            if (expected_events.size() == 0)
                report($sformatf("unexpected event %h", event_item));
            else
            begin
                exp_ev = expected_events.pop_front();
                if (event_item.event_kind !== exp_ev.event_kind)
                    report($sformatf("kind %0d, expected %0d",
                                     event_item.event_kind, exp_ev.event_kind));
                if (event_item.char_code !== exp_ev.char_code)
                    report($sformatf("char_code %h, expected %h",
                                     event_item.char_code, exp_ev.char_code));
                if (event_item.slash_end !== exp_ev.slash_end)
                    report("slash_end differs");
                if (event_item.quirks !== exp_ev.quirks)
                    report("quirks differs");
                if (event_item.last !== exp_ev.last)
                    report("last differs");
            end
        end
        pending = expected_events.size();
    end
endmodule

>>> tb/tb_top.sv
// Top of the HTML tokenizer testbench: clock, reset, byte stimulus with idle
// phases and the verdict. Depends on htok_pkg, htok_checker and the block.
`timescale 1ns / 1ps
module tb_top;
    import htok_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        byte_valid = 0;
    logic        byte_stall;
    byte_item_t  byte_item = '0;
    logic        event_valid;
    logic        event_stall = 0;
    event_item_t event_item;
    int          errors, pending, events_seen;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;
    int          items_sent = 0;
    logic [7:0]  doc[$];
    logic        doc_eoi[$];

    always #6 clk = ~clk;

    html_tokenizer_stream i_dut (.*);

    htok_checker i_checker (.*);

    initial
    begin
        #50ms;
        $display("[html_tokenizer_stream] ERROR");
        $finish;
    end

    // Receiver side: random stalls, or a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            event_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            event_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            doc.push_back(s[i]);
            doc_eoi.push_back(0);
        end
    endtask

    task automatic put_end();
        doc.push_back(8'($urandom));
        doc_eoi.push_back(1);
    endtask

    // Sends everything queued, one item per handshake.
    task automatic send_queued();
        while (doc.size() > 0)
        begin
            @(negedge clk);
            if ($urandom_range(99) < send_idle_pct)
                byte_valid <= 0;
            else
            begin
                byte_valid <= 1;
                byte_item <= '{input_byte: doc.pop_front(), end_of_input: doc_eoi.pop_front()};
                items_sent++;
                @(posedge clk);
                while (byte_stall)
                    @(posedge clk);
            end
        end
        @(negedge clk);
        byte_valid <= 0;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        string alphabet;
        alphabet = "<>/!-=\"' \t\naZdoctypeDOCTYPE[x?";
        r = $urandom_range(9);
        if (r < 7) return alphabet[$urandom_range(alphabet.len()-1)];
        if (r == 7) return 8'h00;
        return 8'($urandom);
    endfunction

    task automatic random_doc(input int n);
        string frags[12];
        frags = '{"<p>", "</div>", "<br/>", "<a href=\"x\" b='y' c=z>", "<!-- hi -->",
                  "<!DOCTYPE html>", "<!doctype  HTML x>", "<!---->", "<!--a--!>",
                  "<?pi>", "<!-- <!-- -->", "</ x>"};
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(2) == 0) put_text(frags[$urandom_range(11)]);
            else
            begin
                doc.push_back(pick_byte());
                doc_eoi.push_back($urandom_range(30) == 0);
            end
        end
    endtask

    task automatic drain();
        while (pending > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: extremes, NUL, high bytes, tags, comments, doctype and cuts.
        put_text("a<1<B/>");
        doc.push_back(8'h00);
        doc_eoi.push_back(0);
        doc.push_back(8'hFF);
        doc_eoi.push_back(0);
        put_text("<!--x--!>");
        put_text("<!DOCTYPEx>");
        put_text("</");
        put_end();
        put_text("<!doc");
        put_end();
        send_queued();
        drain();

        // Random phases: none, sender idle, receiver stalls, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 47 : 29) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 47 : 29) : 0;
            random_doc(17);
            put_end();
            send_queued();
            drain();
        end

        // Long hold-off while items keep coming so the block backs up.
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 60;
        put_text("<!-x--!-->abc</Q/>");
        send_queued();
        drain();

        // CDATA halts the block for the rest of the run.
        put_text("<![CDATA[xy");
        put_end();
        send_queued();
        drain();

        $display("sent %0d byte items, checked %0d events across idle and stall phases",
                 items_sent, events_seen);
        if (errors == 0)
            $display("[html_tokenizer_stream] OK");
        else
            $display("[html_tokenizer_stream] ERROR");
        $finish;
    end
endmodule

>>> sim.f
rtl/htok_pkg.sv
rtl/htok_core.sv
rtl/htok_evq.sv
rtl/html_tokenizer_stream.sv
tb/htok_checker.sv
tb/tb_top.sv
